/* src/jdc_pkg.sv */
// jdc_pkg: shared constants and result types for the julian day converter
`default_nettype none

package jdc_pkg;

  // input tdata packing, lowest bit first
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  // register stages in each datapath, ahead of the output register
  localparam int unsigned PIPE_DEPTH = 7;

  // divide by 100 through a reciprocal, year is 14 bits
  localparam int unsigned DIV100_SH = 21;
  localparam logic [14:0] DIV100_MUL = 15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

  // divide by 146097 (days in 400 years), dividend below 2^25
  localparam int unsigned DIVW_SH = 43;
  localparam logic [25:0] DIVW_MUL =
    26'(((64'd1 << DIVW_SH) + 64'd146096) / 64'd146097);

  // divide by 7305 (20 x 365.25), dividend below 2^28
  localparam int unsigned DIVC_SH = 41;
  localparam logic [28:0] DIVC_MUL = 29'(((64'd1 << DIVC_SH) + 64'd7304) / 64'd7305);

  // multiply by 10000/306001, operand below 512
  localparam int unsigned DIVE_SH = 28;
  localparam logic [23:0] DIVE_MUL =
    24'(((64'd10000 << DIVE_SH) + 64'd306000) / 64'd306001);

  // results of the date to day number path
  typedef struct packed {
    logic [22:0] day_number;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
  } date_res_t;

  // results of the day number to date path
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } num_res_t;

  // operation selector carried in tuser
  typedef enum logic {
    OP_DATE_TO_NUM = 1'b0,
    OP_NUM_TO_DATE = 1'b1
  } op_t;

endpackage

`default_nettype wire

/* src/julian_day_converter.sv */
// julian_day_converter: top level, gregorian date and day number converter
//
// Input stream s_*: one transaction per conversion. s_tuser selects the
// operation: 0 turns year/month/day/hour into a day number (one less before
// noon) with ISO weekday and ordinal day, 1 turns a day number back into
// year/month/day. Output stream m_*: one transaction per input, in order;
// fields that the selected operation does not produce are zero.
// The accepting edge loads the first of seven pipeline stages inside the
// two datapaths, and the output register that drives m_tvalid follows the
// seventh. Throughput is one transaction per cycle while m_tready does not
// hold the output; in the day number path each reciprocal multiply takes
// a stage of its own.
// Reset clears every stage valid bit and m_tvalid; data registers are left
// as they are. When m_tvalid is high and m_tready is low the whole pipeline
// holds, and s_tready drops in the same cycle (s_tready = !m_tvalid ||
// m_tready), so nothing is lost or repeated.
`default_nettype none

module julian_day_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], julian_day[50:28]
  input  wire logic [55:0] s_tdata,
  // op[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // day_number[22:0], out_year[36:23], out_month[40:37], out_day[45:41],
  // weekday[48:46], year_day[57:49]
  output logic [63:0]      m_tdata
);

  logic                           en;
  logic [jdc_pkg::PIPE_DEPTH-1:0] vld;
  jdc_pkg::op_t                   op_pipe [jdc_pkg::PIPE_DEPTH];
  jdc_pkg::date_res_t             date_res;
  jdc_pkg::num_res_t              num_res;
  logic [63:0]                    m_tdata_next;

  // the whole pipeline moves unless a result sits unclaimed
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // datapaths
  jdc_date_pipe u_date (
    .clk   (clk),
    .en    (en),
    .year  (s_tdata[13:0]),
    .month (s_tdata[17:14]),
    .day   (s_tdata[22:18]),
    .hour  (s_tdata[27:23]),
    .res   (date_res)
  );

  jdc_num_pipe u_num (
    .clk        (clk),
    .en         (en),
    .julian_day (s_tdata[50:28]),
    .res        (num_res)
  );

  // stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[jdc_pkg::PIPE_DEPTH-2:0], s_tvalid};
      m_tvalid <= vld[jdc_pkg::PIPE_DEPTH-1];
    end
  end

  // operation code travels beside the data
  always_ff @(posedge clk) begin
    if (en) begin
      op_pipe[0] <= jdc_pkg::op_t'(s_tuser[0]);
      for (int i = 1; i < jdc_pkg::PIPE_DEPTH; i++) begin
        op_pipe[i] <= op_pipe[i-1];
      end
    end
  end

  // output word, unused fields forced to zero
  always_comb begin
    m_tdata_next = '0;
    unique case (op_pipe[jdc_pkg::PIPE_DEPTH-1])
      jdc_pkg::OP_DATE_TO_NUM: begin
        m_tdata_next[22:0]  = date_res.day_number;
        m_tdata_next[48:46] = date_res.weekday;
        m_tdata_next[57:49] = date_res.year_day;
      end
      jdc_pkg::OP_NUM_TO_DATE: begin
        m_tdata_next[36:23] = num_res.year;
        m_tdata_next[40:37] = num_res.month;
        m_tdata_next[45:41] = num_res.day;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= m_tdata_next;
    end
  end

endmodule

`default_nettype wire

/* src/jdc_date_pipe.sv */
// jdc_date_pipe: seven-stage pipeline from year/month/day/hour to day number
`default_nettype none

module jdc_date_pipe (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [13:0]       year,
  input  wire logic [3:0]        month,
  input  wire logic [4:0]        day,
  input  wire logic [4:0]        hour,
  output jdc_pkg::date_res_t     res
);

  // floor(30.6001 * (m + 1)) with jan/feb moved to months 13/14
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd397;
      4'd1:    r = 9'd428;
      4'd2:    r = 9'd459;
      4'd3:    r = 9'd122;
      4'd4:    r = 9'd153;
      4'd5:    r = 9'd183;
      4'd6:    r = 9'd214;
      4'd7:    r = 9'd244;
      4'd8:    r = 9'd275;
      4'd9:    r = 9'd306;
      4'd10:   r = 9'd336;
      4'd11:   r = 9'd367;
      4'd12:   r = 9'd397;
      4'd13:   r = 9'd428;
      4'd14:   r = 9'd459;
      default: r = 9'd489;
    endcase
    return r;
  endfunction

  // days before the first of the month, non-leap year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // stage 1 registers
  logic [13:0] year1;
  logic        adj1;
  logic        bn1;
  logic        mgt2_1;
  logic [28:0] p100_1;
  logic [24:0] p1461_1;
  logic [8:0]  ybase1;
  logic [8:0]  moff1;
  logic [4:0]  day1;
  logic        adj_in;
  logic [14:0] ysh_in;

  // stage 2 registers
  logic [7:0]  cent2;
  logic        leap2;
  logic [22:0] q365_2;
  logic [8:0]  ybase2;
  logic [8:0]  moff2;
  logic [4:0]  day2;
  logic        bn2;
  logic        mgt2_2;
  logic [7:0]  qy;
  logic [6:0]  rem;
  logic        rem_zero;

  // stage 3 to 7 registers
  logic [23:0] part3;
  logic [23:0] corr3;
  logic [8:0]  yd3;
  logic        bn3;
  logic [23:0] noon4;
  logic [22:0] jd4;
  logic [8:0]  yd4;
  logic [5:0]  dsum5;
  logic [22:0] jd5;
  logic [8:0]  yd5;
  logic [2:0]  wd6;
  logic [22:0] jd6;
  logic [8:0]  yd6;
  logic [22:0] jd7;
  logic [2:0]  wd7;
  logic [8:0]  yd7;
  logic [5:0]  dsum_next;
  logic [3:0]  fold;
  logic [2:0]  mod7;

  // stage 1: shift jan/feb into the previous year, start both multiplies
  assign adj_in = (month < 4'd3);
  assign ysh_in = 15'(year) - 15'(adj_in) + 15'd4716;

  always_ff @(posedge clk) begin
    if (en) begin
      year1   <= year;
      adj1    <= adj_in;
      bn1     <= (hour < 5'd12);
      mgt2_1  <= (month > 4'd2);
      p100_1  <= 29'(29'(year) * 29'(jdc_pkg::DIV100_MUL));
      p1461_1 <= 25'(25'(ysh_in) * 25'd1461);
      ybase1  <= month_start(month) + 9'(day);
      moff1   <= month_offset(month);
      day1    <= day;
    end
  end

  // stage 2: century of the shifted year and the leap test
  assign qy       = p100_1[28:21];
  assign rem      = 7'(year1 - 14'(14'(qy) * 14'd100));
  assign rem_zero = (rem == 7'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      cent2  <= (adj1 && rem_zero && qy != 8'd0) ? qy - 8'd1 : qy;
      leap2  <= (year1[1:0] == 2'd0) && (!rem_zero || qy[1:0] == 2'd0);
      q365_2 <= p1461_1[24:2];
      ybase2 <= ybase1;
      moff2  <= moff1;
      day2   <= day1;
      bn2    <= bn1;
      mgt2_2 <= mgt2_1;
    end
  end

  // stage 3: partial sums, gregorian correction, ordinal day
  always_ff @(posedge clk) begin
    if (en) begin
      part3 <= 24'(q365_2) + 24'(moff2) + 24'(day2) - 24'd1524;
      corr3 <= 24'd2 - 24'(cent2) + 24'(cent2[7:2]);
      yd3   <= ybase2 + 9'(mgt2_2 && leap2);
      bn3   <= bn2;
    end
  end

  // stage 4: noon day number and the pre-noon value
  always_ff @(posedge clk) begin
    if (en) begin
      noon4 <= part3 + corr3;
      jd4   <= 23'(part3 + corr3 - 24'(bn3));
      yd4   <= yd3;
    end
  end

  // stage 5: octal digit sum, since 8 mod 7 is 1
  always_comb begin
    dsum_next = '0;
    for (int i = 0; i < 8; i++) begin
      dsum_next = dsum_next + 6'(noon4[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsum5 <= dsum_next;
      jd5   <= jd4;
      yd5   <= yd4;
    end
  end

  // stage 6: fold digit sum down to the remainder mod 7
  assign fold = 4'(dsum5[5:3]) + 4'(dsum5[2:0]);
  assign mod7 = (fold >= 4'd14) ? 3'd0 :
                (fold >= 4'd7)  ? 3'(fold - 4'd7) : fold[2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      wd6 <= mod7 + 3'd1;
      jd6 <= jd5;
      yd6 <= yd5;
    end
  end

  // stage 7: align with the day number to date path
  always_ff @(posedge clk) begin
    if (en) begin
      jd7 <= jd6;
      wd7 <= wd6;
      yd7 <= yd6;
    end
  end

  assign res.day_number = jd7;
  assign res.weekday    = wd7;
  assign res.year_day   = yd7;

endmodule

`default_nettype wire

/* src/jdc_num_pipe.sv */
// jdc_num_pipe: seven-stage pipeline from day number to year/month/day
`default_nettype none

module jdc_num_pipe (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [22:0]     julian_day,
  output jdc_pkg::num_res_t    res
);

  // floor(30.6001 * k)
  function automatic logic [8:0] month_days(input logic [3:0] k);
    logic [8:0] r;
    unique case (k)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  logic [23:0]        z_in;
  logic signed [26:0] nn;
  logic               neg_in;

  logic [23:0] z1;
  logic        neg1;
  logic [24:0] absn1;
  logic [23:0] z2;
  logic        neg2;
  logic [50:0] pw2;
  logic [7:0]  wq;
  logic [7:0]  gap;
  logic [23:0] b3;
  logic [23:0] b4;
  logic [27:0] t4;
  logic [23:0] b5;
  logic [56:0] pc5;
  logic [15:0] c_next;
  logic [26:0] dprod;
  logic [15:0] c6;
  logic [23:0] b6;
  logic [23:0] d6;
  logic [8:0]  v_next;
  logic [15:0] c7;
  logic [8:0]  v7;
  logic [31:0] pe7;
  logic [3:0]  e;
  logic        early;

  // stage 1: offset day number, signed numerator and its magnitude
  assign z_in   = 24'(julian_day) + 24'd1;
  assign nn     = $signed({1'b0, z_in, 2'b00}) - 27'sd7468865;
  assign neg_in = nn[26];

  always_ff @(posedge clk) begin
    if (en) begin
      z1    <= z_in;
      neg1  <= neg_in;
      absn1 <= neg_in ? 25'(-nn) : 25'(nn);
    end
  end

  // stage 2: reciprocal multiply for the 400-year quotient
  always_ff @(posedge clk) begin
    if (en) begin
      z2   <= z1;
      neg2 <= neg1;
      pw2  <= 51'(51'(absn1) * 51'(jdc_pkg::DIVW_MUL));
    end
  end

  // stage 3: w - w/4 with truncation toward zero, then b
  assign wq  = pw2[50:43];
  assign gap = wq - 8'(wq[7:2]);

  always_ff @(posedge clk) begin
    if (en) begin
      b3 <= neg2 ? z2 + 24'd1525 - 24'(gap) : z2 + 24'd1525 + 24'(gap);
    end
  end

  // stage 4: numerator of the year estimate
  always_ff @(posedge clk) begin
    if (en) begin
      b4 <= b3;
      t4 <= 28'(28'(b3) * 28'd20) - 28'd2442;
    end
  end

  // stage 5: reciprocal multiply for the year estimate
  always_ff @(posedge clk) begin
    if (en) begin
      b5  <= b4;
      pc5 <= 57'(57'(t4) * 57'(jdc_pkg::DIVC_MUL));
    end
  end

  // stage 6: year count c and floor(365.25 c)
  assign c_next = pc5[56:41];
  assign dprod  = 27'(c_next) * 27'd1461;

  always_ff @(posedge clk) begin
    if (en) begin
      c6 <= c_next;
      b6 <= b5;
      d6 <= 24'(dprod >> 2);
    end
  end

  // stage 7: days into the year, month estimate multiply
  assign v_next = 9'(b6 - d6);

  always_ff @(posedge clk) begin
    if (en) begin
      c7  <= c6;
      v7  <= v_next;
      pe7 <= 32'(33'(v_next) * 33'(jdc_pkg::DIVE_MUL));
    end
  end

  // month, day and year from the month estimate
  assign e     = pe7[31:28];
  assign early = (e >= 4'd14) || (e <= 4'd3);

  assign res.month = (e > 4'd13) ? e - 4'd13 : e - 4'd1;
  assign res.day   = 5'(v7 - month_days(e));
  assign res.year  = 14'(c7 - (early ? 16'd4715 : 16'd4716));

endmodule

`default_nettype wire

/* src/jdc_checker.sv */
// jdc_checker: port-level assertions for julian_day_converter and its bind
`default_nettype none

module jdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] s_tdata,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // a waiting input transaction is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input transaction changed while waiting");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input is taken exactly when the pipeline can move
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow the output stall");

  // one operation's fields only, weekday present with a day number
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:0] == 23'd0 || m_tdata[45:23] == 23'd0)
                 && ((m_tdata[48:46] != 3'd0) == (m_tdata[22:0] != 23'd0))
                 && (m_tdata[63:58] == 6'd0))
    else $error("output mixes fields of both operations");

endmodule

bind julian_day_converter jdc_checker u_jdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
